// ===== hdl/i2c_snoop_bit_override_top_macros.svh =====
// Assertion macros for the I2C snoop bit override block.
// Included by the top level; needs no package.
`ifndef I2C_SNOOP_BIT_OVERRIDE_TOP_MACROS_SVH
`define I2C_SNOOP_BIT_OVERRIDE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SBO_ASSERT_SAME(lbl, ck, rst, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rst) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBO_ASSERT_NEXT(lbl, ck, rst, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rst) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBO_ASSERT_SAME(lbl, ck, rst, ante, cons)
`define SBO_ASSERT_NEXT(lbl, ck, rst, ante, cons)
`endif
`endif

// ===== hdl/i2csbo_pkg.sv =====
// Types and constants for the I2C snoop bit override block.
// No dependencies.
`timescale 1ns / 1ps

package i2csbo_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGISTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_REGISTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BIT      = 3'd4;

    localparam logic [6:0] DEVICE_ADDRESS_RST  = 7'h38;
    localparam logic [7:0] FIRST_REGISTER_RST  = 8'h07;
    localparam logic [2:0] FIRST_BIT_RST       = 3'd4;
    localparam logic [7:0] SECOND_REGISTER_RST = 8'h40;
    localparam logic [2:0] SECOND_BIT_RST      = 3'd0;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_REG,
        PH_OVR,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] first_register;
        logic [2:0] first_bit;
        logic [7:0] second_register;
        logic [2:0] second_bit;
    } cfg_t;

    typedef struct packed {
        logic sda_pull_low;
        logic in_transfer;
    } res_t;

endpackage

// ===== hdl/i2csbo_if.sv =====
// Handshake channels of the I2C snoop bit override block: bus samples in, results out.
// No dependencies.
`timescale 1ns / 1ps

interface i2csbo_sample_if;
    logic valid;
    logic ready;
    logic scl;
    logic sda;

    modport source (output valid, output scl, output sda, input ready);
    modport sink (input valid, input scl, input sda, output ready);
endinterface

interface i2csbo_result_if;
    logic valid;
    logic ready;
    logic sda_pull_low;
    logic in_transfer;

    modport source (output valid, output sda_pull_low, output in_transfer, input ready);
    modport sink (input valid, input sda_pull_low, input in_transfer, output ready);
endinterface

// ===== hdl/i2csbo_cfg.sv =====
// Configuration register file of the I2C snoop bit override block.
// Depends on i2csbo_pkg.
`timescale 1ns / 1ps

module i2csbo_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [i2csbo_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [i2csbo_pkg::CFG_DATA_W-1:0] wr_data,
    output i2csbo_pkg::cfg_t                 cfg
);

    i2csbo_pkg::cfg_t cfg_reg;
    i2csbo_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                i2csbo_pkg::CFG_DEVICE_ADDRESS:  cfg_next.device_address  = wr_data[6:0];
                i2csbo_pkg::CFG_FIRST_REGISTER:  cfg_next.first_register  = wr_data[7:0];
                i2csbo_pkg::CFG_FIRST_BIT:       cfg_next.first_bit       = wr_data[2:0];
                i2csbo_pkg::CFG_SECOND_REGISTER: cfg_next.second_register = wr_data[7:0];
                i2csbo_pkg::CFG_SECOND_BIT:      cfg_next.second_bit      = wr_data[2:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address  <= i2csbo_pkg::DEVICE_ADDRESS_RST;
            cfg_reg.first_register  <= i2csbo_pkg::FIRST_REGISTER_RST;
            cfg_reg.first_bit       <= i2csbo_pkg::FIRST_BIT_RST;
            cfg_reg.second_register <= i2csbo_pkg::SECOND_REGISTER_RST;
            cfg_reg.second_bit      <= i2csbo_pkg::SECOND_BIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/i2csbo_core.sv =====
// Bus tracking state machine: START/STOP detect, byte shifter, register capture, bit override.
// Depends on i2csbo_pkg.
`timescale 1ns / 1ps

module i2csbo_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  i2csbo_pkg::cfg_t  cfg,
    input  logic              accept,
    input  logic              scl,
    input  logic              sda,
    output i2csbo_pkg::res_t  res
);

    i2csbo_pkg::phase_t phase_reg, phase_next;
    logic       prev_clk_reg, prev_clk_next;
    logic       prev_data_reg, prev_data_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] last_register_reg, last_register_next;
    logic [2:0] force_pos_reg, force_pos_next;
    logic       drive_low_reg, drive_low_next;

    logic rise;
    logic fall;
    logic bus_cond;

    assign rise     = !prev_clk_reg && scl;
    assign fall     = prev_clk_reg && !scl;
    assign bus_cond = scl && prev_clk_reg && (sda != prev_data_reg);

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        prev_clk_next      = prev_clk_reg;
        prev_data_next     = prev_data_reg;
        bit_cnt_next       = bit_cnt_reg;
        shift_next         = shift_reg;
        last_register_next = last_register_reg;
        force_pos_next     = force_pos_reg;
        drive_low_next     = drive_low_reg;
        if (accept)
        begin
            prev_clk_next  = scl;
            prev_data_next = sda;
            if (bus_cond)
            begin
                // falling SDA is START, rising is STOP
                phase_next     = sda ? i2csbo_pkg::PH_IDLE : i2csbo_pkg::PH_ADDR;
                bit_cnt_next   = 4'd0;
                shift_next     = 8'd0;
                drive_low_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    i2csbo_pkg::PH_ADDR, i2csbo_pkg::PH_REG:
                    begin
                        if (rise)
                        begin
                            if (bit_cnt_reg < i2csbo_pkg::BITS_PER_BYTE)
                            begin
                                shift_next   = {shift_reg[6:0], sda};
                                bit_cnt_next = bit_cnt_reg + 4'd1;
                            end
                            else
                            begin
                                // ACK clock closes the byte
                                bit_cnt_next = 4'd0;
                                shift_next   = 8'd0;
                                if (phase_reg == i2csbo_pkg::PH_REG)
                                begin
                                    last_register_next = shift_reg;
                                    phase_next         = i2csbo_pkg::PH_DONE;
                                end
                                else if (shift_reg == {cfg.device_address, 1'b0})
                                begin
                                    phase_next = i2csbo_pkg::PH_REG;
                                end
                                else if (shift_reg == {cfg.device_address, 1'b1})
                                begin
                                    last_register_next = 8'd0;
                                    if (last_register_reg == cfg.first_register)
                                    begin
                                        force_pos_next = cfg.first_bit;
                                        phase_next     = i2csbo_pkg::PH_OVR;
                                    end
                                    else if (last_register_reg == cfg.second_register)
                                    begin
                                        force_pos_next = cfg.second_bit;
                                        phase_next     = i2csbo_pkg::PH_OVR;
                                    end
                                    else
                                    begin
                                        phase_next = i2csbo_pkg::PH_DONE;
                                    end
                                end
                                else
                                begin
                                    phase_next = i2csbo_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                    i2csbo_pkg::PH_OVR:
                    begin
                        if (rise)
                        begin
                            if (bit_cnt_reg < i2csbo_pkg::BITS_PER_BYTE)
                            begin
                                bit_cnt_next = bit_cnt_reg + 4'd1;
                            end
                        end
                        else if (fall)
                        begin
                            if (drive_low_reg)
                            begin
                                drive_low_next = 1'b0;
                                phase_next     = i2csbo_pkg::PH_DONE;
                            end
                            else if (bit_cnt_reg == {1'b0, ~force_pos_reg})
                            begin
                                // bit 7 goes first, so position p is bit index 7-p
                                drive_low_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // result from the updated state
    always_comb
    begin
        res.sda_pull_low = drive_low_next;
        res.in_transfer  = (phase_next != i2csbo_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2csbo_pkg::PH_IDLE;
            prev_clk_reg      <= 1'b1;
            prev_data_reg     <= 1'b1;
            bit_cnt_reg       <= 4'd0;
            shift_reg         <= 8'd0;
            last_register_reg <= 8'd0;
            force_pos_reg     <= 3'd0;
            drive_low_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            prev_clk_reg      <= prev_clk_next;
            prev_data_reg     <= prev_data_next;
            bit_cnt_reg       <= bit_cnt_next;
            shift_reg         <= shift_next;
            last_register_reg <= last_register_next;
            force_pos_reg     <= force_pos_next;
            drive_low_reg     <= drive_low_next;
        end
    end

endmodule

// ===== hdl/i2csbo_obuf.sv =====
// Result register with skid stage; decouples the result channel from the sample channel.
// Depends on i2csbo_pkg.
`timescale 1ns / 1ps

module i2csbo_obuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2csbo_pkg::res_t push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output i2csbo_pkg::res_t out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    i2csbo_pkg::res_t out_data_reg, out_data_next;
    i2csbo_pkg::res_t skid_data_reg, skid_data_next;
    logic             pop;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

// ===== hdl/i2c_snoop_bit_override_top.sv =====
// channel   dir  payload                      accepted when
// sample    in   scl, sda                     sample.valid && sample.ready
// result    out  sda_pull_low, in_transfer    result.valid && result.ready
// config    in   wr_index, wr_data            wr_en
//
// One word per cycle while sample.ready is high; each result is registered.
// The state update is a single pass of the bus state machine in i2csbo_core.
// Reset brings the bus tracker to idle with both lines seen high.
// A stalled result sits in the output register; one more sample fits the skid
// stage, then sample.ready drops until the result side drains.
// Top level of the I2C snoop bit override block; uses i2csbo_pkg, the channel
// interfaces, i2csbo_cfg, i2csbo_core, i2csbo_obuf and the assertion macros.
`timescale 1ns / 1ps
`include "i2c_snoop_bit_override_top_macros.svh"

module i2c_snoop_bit_override_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [i2csbo_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [i2csbo_pkg::CFG_DATA_W-1:0]  wr_data,
    i2csbo_sample_if.sink                      sample,
    i2csbo_result_if.source                    result
);

    i2csbo_pkg::cfg_t cfg;
    i2csbo_pkg::res_t core_res;
    i2csbo_pkg::res_t out_data;
    logic             accept;
    logic             buf_ready;

    assign accept       = sample.valid && buf_ready;
    assign sample.ready = buf_ready;

    i2csbo_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    i2csbo_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .scl    (sample.scl),
        .sda    (sample.sda),
        .res    (core_res)
    );

    i2csbo_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_res),
        .push_ready (buf_ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (out_data)
    );

    assign result.sda_pull_low = out_data.sda_pull_low;
    assign result.in_transfer  = out_data.in_transfer;

    `SBO_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, sample.valid && sample.ready, result.valid)
    `SBO_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !sample.ready, result.valid)
    `SBO_ASSERT_SAME(a_pull_inside_transfer, clk, rst_n, result.valid && result.sda_pull_low, result.in_transfer)

endmodule
